// ----- rtl/biq_pkg.sv -----
`timescale 1ns / 1ps
// Package for the Q31 biquad cascade filter: widths, register map, command
// encoding and the step program that sequences the shared multiplier.
// Used by every module of the filter; depends on nothing else.
package biq_pkg;

    localparam int DATA_W   = 32;
    localparam int PROD_W   = 64;
    localparam int NUM_REGS = 8;
    localparam int SECTIONS = 3;
    localparam int GAINS    = 4;
    localparam int ADDR_W   = 5;
    localparam int STEP_W   = 5;

    localparam logic [STEP_W-1:0] LAST_STEP = 5'd19;

    localparam logic signed [DATA_W-1:0] B0_COEF = 32'sh7FFF_FFFF;

    typedef enum logic [2:0] {
        REG_GAIN_FIRST   = 3'd0,
        REG_GAIN_SECOND  = 3'd1,
        REG_GAIN_THIRD   = 3'd2,
        REG_GAIN_FINAL   = 3'd3,
        REG_A1           = 3'd4,
        REG_A2_ONE       = 3'd5,
        REG_A2_TWO       = 3'd6,
        REG_A2_THREE     = 3'd7
    } reg_idx_t;

    localparam logic [DATA_W-1:0] RST_GAIN_FIRST  = 32'd9117545;
    localparam logic [DATA_W-1:0] RST_GAIN_SECOND = 32'd9117545;
    localparam logic [DATA_W-1:0] RST_GAIN_THIRD  = 32'd9098292;
    localparam logic [DATA_W-1:0] RST_GAIN_FINAL  = 32'd2147483647;
    localparam logic [DATA_W-1:0] RST_A1          = 32'h8000_0000;
    localparam logic [DATA_W-1:0] RST_A2_ONE      = 32'd2138011531;
    localparam logic [DATA_W-1:0] RST_A2_TWO      = 32'd2138720858;
    localparam logic [DATA_W-1:0] RST_A2_THREE    = 32'd2129287064;

    typedef struct packed {
        logic [GAINS-1:0][DATA_W-1:0]    gain;
        logic [DATA_W-1:0]               a1;
        logic [SECTIONS-1:0][DATA_W-1:0] a2;
    } cfg_t;

    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } state_t;

    typedef enum logic [1:0] {
        MA_GAIN,
        MA_A1,
        MA_A2,
        MA_B0
    } mul_a_sel_t;

    typedef enum logic [1:0] {
        MB_ACC,
        MB_D1,
        MB_D2
    } mul_b_sel_t;

    typedef enum logic [1:0] {
        ACC_NONE,
        ACC_PROD,
        ACC_SUB,
        ACC_OUTPUT
    } acc_op_t;

    typedef struct packed {
        logic       load_in;
        logic       mul_en;
        mul_a_sel_t mul_a;
        mul_b_sel_t mul_b;
        acc_op_t    acc_op;
        logic [1:0] sec;
        logic [1:0] gain_idx;
        logic       out_load;
    } cmd_t;

    localparam cmd_t CMD_NOP = '{
        load_in:  1'b0,
        mul_en:   1'b0,
        mul_a:    MA_GAIN,
        mul_b:    MB_ACC,
        acc_op:   ACC_NONE,
        sec:      2'd0,
        gain_idx: 2'd0,
        out_load: 1'b0
    };

    // Each section takes six steps: two feedback products are subtracted from
    // the accumulator, the result is scaled by b0, and the b2 term reduces to
    // subtracting the older delay word. A gain product separates the sections.
    function automatic cmd_t step_cmd(input logic [STEP_W-1:0] step);
        cmd_t c;
        c = CMD_NOP;
        case (step)
            5'd0, 5'd6, 5'd12, 5'd18:
            begin
                c.mul_en   = 1'b1;
                c.mul_a    = MA_GAIN;
                c.mul_b    = MB_ACC;
                c.gain_idx = (step == 5'd0)  ? 2'd0 :
                             (step == 5'd6)  ? 2'd1 :
                             (step == 5'd12) ? 2'd2 : 2'd3;
            end
            5'd1, 5'd7, 5'd13:
            begin
                c.mul_en = 1'b1;
                c.mul_a  = MA_A1;
                c.mul_b  = MB_D1;
                c.acc_op = ACC_PROD;
            end
            5'd2, 5'd8, 5'd14:
            begin
                c.mul_en = 1'b1;
                c.mul_a  = MA_A2;
                c.mul_b  = MB_D2;
                c.acc_op = ACC_SUB;
            end
            5'd3, 5'd9, 5'd15:
            begin
                c.acc_op = ACC_SUB;
            end
            5'd4, 5'd10, 5'd16:
            begin
                c.mul_en = 1'b1;
                c.mul_a  = MA_B0;
                c.mul_b  = MB_ACC;
            end
            5'd5, 5'd11, 5'd17:
            begin
                c.acc_op = ACC_OUTPUT;
            end
            5'd19:
            begin
                c.out_load = 1'b1;
            end
            default:
            begin
                c = CMD_NOP;
            end
        endcase
        if (step < 5'd6) begin
            c.sec = 2'd0;
        end else if (step < 5'd12) begin
            c.sec = 2'd1;
        end else begin
            c.sec = 2'd2;
        end
        return c;
    endfunction

endpackage

// ----- rtl/biq_in_if.sv -----
`timescale 1ns / 1ps
// Input sample channel of the biquad cascade filter.
// Depends on biq_pkg for the data width.
interface biq_in_if;
    logic                            valid;
    logic                            ready;
    logic signed [biq_pkg::DATA_W-1:0] sample_in;

    modport source (output valid, output sample_in, input ready);
    modport sink (input valid, input sample_in, output ready);
endinterface

// ----- rtl/biq_out_if.sv -----
`timescale 1ns / 1ps
// Output sample channel of the biquad cascade filter.
// Depends on biq_pkg for the data width.
interface biq_out_if;
    logic                            valid;
    logic                            ready;
    logic signed [biq_pkg::DATA_W-1:0] sample_out;

    modport source (output valid, output sample_out, input ready);
    modport sink (input valid, input sample_out, output ready);
endinterface

// ----- rtl/biq_cfg.sv -----
`timescale 1ns / 1ps
// APB register file holding the gains and feedback coefficients.
// Depends on biq_pkg for the register map and reset values.
module biq_cfg
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [biq_pkg::ADDR_W-1:0]  paddr,
    input  logic [biq_pkg::DATA_W-1:0]  pwdata,
    output logic [biq_pkg::DATA_W-1:0]  prdata,
    output logic                        pready,
    output biq_pkg::cfg_t               cfg
);

    logic [biq_pkg::NUM_REGS-1:0][biq_pkg::DATA_W-1:0] regs_reg;
    logic [2:0]                                        idx;
    logic                                              wr_en;

    assign idx    = paddr[biq_pkg::ADDR_W-1:2];
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign prdata = regs_reg[idx];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            regs_reg[biq_pkg::REG_GAIN_FIRST]  <= biq_pkg::RST_GAIN_FIRST;
            regs_reg[biq_pkg::REG_GAIN_SECOND] <= biq_pkg::RST_GAIN_SECOND;
            regs_reg[biq_pkg::REG_GAIN_THIRD]  <= biq_pkg::RST_GAIN_THIRD;
            regs_reg[biq_pkg::REG_GAIN_FINAL]  <= biq_pkg::RST_GAIN_FINAL;
            regs_reg[biq_pkg::REG_A1]          <= biq_pkg::RST_A1;
            regs_reg[biq_pkg::REG_A2_ONE]      <= biq_pkg::RST_A2_ONE;
            regs_reg[biq_pkg::REG_A2_TWO]      <= biq_pkg::RST_A2_TWO;
            regs_reg[biq_pkg::REG_A2_THREE]    <= biq_pkg::RST_A2_THREE;
        end else if (wr_en) begin
            regs_reg[idx] <= pwdata;
        end
    end

    always_comb
    begin
        cfg.gain[0] = regs_reg[biq_pkg::REG_GAIN_FIRST];
        cfg.gain[1] = regs_reg[biq_pkg::REG_GAIN_SECOND];
        cfg.gain[2] = regs_reg[biq_pkg::REG_GAIN_THIRD];
        cfg.gain[3] = regs_reg[biq_pkg::REG_GAIN_FINAL];
        cfg.a1      = regs_reg[biq_pkg::REG_A1];
        cfg.a2[0]   = regs_reg[biq_pkg::REG_A2_ONE];
        cfg.a2[1]   = regs_reg[biq_pkg::REG_A2_TWO];
        cfg.a2[2]   = regs_reg[biq_pkg::REG_A2_THREE];
    end

endmodule

// ----- rtl/biq_ctrl.sv -----
`timescale 1ns / 1ps
// Controller of the biquad cascade: steps through the multiplier program and
// runs the input and output handshakes. Depends on biq_pkg.
module biq_ctrl
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    output logic                 out_valid,
    input  logic                 out_ready,
    output biq_pkg::cmd_t        cmd
);

    biq_pkg::state_t                  state_reg;
    biq_pkg::state_t                  state_next;
    logic [biq_pkg::STEP_W-1:0]       step_reg;
    logic [biq_pkg::STEP_W-1:0]       step_next;
    logic                             out_valid_reg;
    logic                             out_valid_next;
    logic                             advance;
    logic                             last;
    logic                             accept;

    assign last    = (step_reg == biq_pkg::LAST_STEP);
    assign accept  = in_valid && (state_reg == biq_pkg::ST_IDLE);
    assign advance = (state_reg == biq_pkg::ST_RUN) &&
                     (!last || !out_valid_reg || out_ready);

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        case (state_reg)
            biq_pkg::ST_IDLE:
            begin
                step_next = '0;
                if (accept) begin
                    state_next = biq_pkg::ST_RUN;
                end
            end
            biq_pkg::ST_RUN:
            begin
                if (advance) begin
                    if (last) begin
                        state_next = biq_pkg::ST_IDLE;
                        step_next  = '0;
                    end else begin
                        step_next = step_reg + 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = biq_pkg::ST_IDLE;
                step_next  = '0;
            end
        endcase
    end

    always_comb
    begin
        in_ready = (state_reg == biq_pkg::ST_IDLE);
        cmd      = biq_pkg::CMD_NOP;
        case (state_reg)
            biq_pkg::ST_IDLE:
            begin
                cmd.load_in = accept;
            end
            biq_pkg::ST_RUN:
            begin
                if (advance) begin
                    cmd = biq_pkg::step_cmd(step_reg);
                end
            end
            default:
            begin
                cmd = biq_pkg::CMD_NOP;
            end
        endcase
        if (cmd.out_load) begin
            out_valid_next = 1'b1;
        end else if (out_ready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    assign out_valid = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg     <= biq_pkg::ST_IDLE;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// ----- rtl/biq_dp.sv -----
`timescale 1ns / 1ps
// Datapath of the biquad cascade: one shared Q31 multiplier, an accumulator,
// the section delay words and the output register. Depends on biq_pkg.
module biq_dp
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  biq_pkg::cmd_t                      cmd,
    input  biq_pkg::cfg_t                      cfg,
    input  logic signed [biq_pkg::DATA_W-1:0]  sample_in,
    output logic signed [biq_pkg::DATA_W-1:0]  sample_out
);

    logic signed [biq_pkg::PROD_W-1:0]                 prod_reg;
    logic signed [biq_pkg::PROD_W-1:0]                 prod_next;
    logic signed [biq_pkg::DATA_W-1:0]                 acc_reg;
    logic signed [biq_pkg::DATA_W-1:0]                 out_reg;
    logic [biq_pkg::SECTIONS-1:0][biq_pkg::DATA_W-1:0] d1_reg;
    logic [biq_pkg::SECTIONS-1:0][biq_pkg::DATA_W-1:0] d2_reg;
    logic signed [biq_pkg::DATA_W-1:0]                 op_a;
    logic signed [biq_pkg::DATA_W-1:0]                 op_b;
    logic signed [biq_pkg::DATA_W-1:0]                 q;
    logic signed [biq_pkg::DATA_W-1:0]                 d1_sel;
    logic signed [biq_pkg::DATA_W-1:0]                 d2_sel;

    assign d1_sel = d1_reg[cmd.sec];
    assign d2_sel = d2_reg[cmd.sec];
    assign q      = prod_reg[biq_pkg::PROD_W-2:biq_pkg::DATA_W-1];

    always_comb
    begin
        case (cmd.mul_a)
            biq_pkg::MA_GAIN: op_a = cfg.gain[cmd.gain_idx];
            biq_pkg::MA_A1:   op_a = cfg.a1;
            biq_pkg::MA_A2:   op_a = cfg.a2[cmd.sec];
            biq_pkg::MA_B0:   op_a = biq_pkg::B0_COEF;
            default:          op_a = '0;
        endcase
        case (cmd.mul_b)
            biq_pkg::MB_ACC: op_b = acc_reg;
            biq_pkg::MB_D1:  op_b = d1_sel;
            biq_pkg::MB_D2:  op_b = d2_sel;
            default:         op_b = '0;
        endcase
        prod_next = op_a * op_b;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.mul_en) begin
            prod_reg <= prod_next;
        end
        if (cmd.load_in) begin
            acc_reg <= sample_in;
        end else begin
            case (cmd.acc_op)
                biq_pkg::ACC_PROD:   acc_reg <= q;
                biq_pkg::ACC_SUB:    acc_reg <= acc_reg - q;
                biq_pkg::ACC_OUTPUT: acc_reg <= q - d2_sel;
                default:             acc_reg <= acc_reg;
            endcase
        end
        if (cmd.out_load) begin
            out_reg <= q;
        end
    end

    // The section output step also shifts the delay line: the new w sits in
    // the accumulator until this edge.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            d1_reg <= '0;
            d2_reg <= '0;
        end else if (cmd.acc_op == biq_pkg::ACC_OUTPUT && !cmd.load_in) begin
            d1_reg[cmd.sec] <= acc_reg;
            d2_reg[cmd.sec] <= d1_sel;
        end
    end

    assign sample_out = out_reg;

endmodule

// ----- rtl/q31_biquad_cascade_filter.sv -----
`timescale 1ns / 1ps
// Top level of the Q31 biquad cascade filter: three direct-form-II sections
// with gains, sharing one multiplier. Depends on biq_pkg, the channel
// interfaces, biq_cfg, biq_ctrl and biq_dp.
//
// Usage:
// Samples enter on in_chan and leave on out_chan; each channel completes a
// transaction at a clock edge where valid and ready are both high.
// Coefficients are written through the APB port, by the user only while the
// filter is idle; the block itself does not enforce this. Register i sits at
// byte address 4*i and pready is always high. After an input transaction the
// filter runs a 20-step program on its single 32x32 multiplier, one step per
// cycle unless its last step waits for the receiver; then the result becomes
// valid. The input is ready again in that same cycle, and a new sample is
// accepted only in the idle state, while no program is running.
// The output register holds a finished sample while the receiver stalls, and
// the next sample may be accepted meanwhile; its program then waits in its
// last step until the held sample is taken.
// Reset clears all delay words, restores the default coefficients and leaves
// both channels empty.
module q31_biquad_cascade_filter
(
    input  logic                        clk,
    input  logic                        rst_n,
    biq_in_if.sink                      in_chan,
    biq_out_if.source                   out_chan,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [biq_pkg::ADDR_W-1:0]  paddr,
    input  logic [biq_pkg::DATA_W-1:0]  pwdata,
    output logic [biq_pkg::DATA_W-1:0]  prdata,
    output logic                        pready
);

    biq_pkg::cfg_t cfg;
    biq_pkg::cmd_t cmd;

    biq_cfg u_cfg
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    biq_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_chan.valid),
        .in_ready  (in_chan.ready),
        .out_valid (out_chan.valid),
        .out_ready (out_chan.ready),
        .cmd       (cmd)
    );

    biq_dp u_dp
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .cfg        (cfg),
        .sample_in  (in_chan.sample_in),
        .sample_out (out_chan.sample_out)
    );

endmodule
